// ----- hw/rtl/kuf_pkg.sv -----
`default_nettype none
package kuf_pkg;

    // Field widths fixed by the item format
    localparam int VTX_W    = 5;   // vertex index
    localparam int SIZE_W   = 6;   // set size, up to 32
    localparam int NCNT_W   = 6;   // node_count register
    localparam int EDGE_W   = 5;   // accepted tree-edge count

    // Vertices are 5 bits wide, so at most 32 nodes take part
    localparam int VTX_LIMIT     = 32;
    localparam int MAX_NODES_DEF = 32;

    // Stream data widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Action codes carried on s_tuser
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_WR_LO,
        ST_WR_HI,
        ST_EMIT
    } kuf_state_t;

    // Request from the sequencer to the forest memory
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [VTX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [VTX_W-1:0]  wr_addr;
        logic [VTX_W-1:0]  wr_parent;
        logic [SIZE_W-1:0] wr_size;
    } kuf_mem_req_t;

    // Registered read data, available in the cycle after the read
    typedef struct packed {
        logic [VTX_W-1:0]  node;
        logic [VTX_W-1:0]  parent;
        logic [SIZE_W-1:0] size;
    } kuf_mem_rsp_t;

    // Sequencer status seen by the top level
    typedef struct packed {
        kuf_state_t        state;
        logic [EDGE_W-1:0] count;
    } kuf_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kuf_mem.sv -----
`default_nettype none
module kuf_mem #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire kuf_pkg::kuf_mem_req_t req,
    output kuf_pkg::kuf_mem_rsp_t      rsp
);
    import kuf_pkg::*;

    localparam int LIM   = (MAX_NODES < VTX_LIMIT) ? MAX_NODES : VTX_LIMIT;
    localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;

    logic [IDX_W-1:0]  parent_mem [LIM];
    logic [SIZE_W-1:0] size_mem   [LIM];
    logic [LIM-1:0]    valid_reg;

    logic [IDX_W-1:0]  rd_parent_reg;
    logic [SIZE_W-1:0] rd_size_reg;
    logic [VTX_W-1:0]  rd_node_reg;
    logic              rd_valid_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;

    assign rd_idx = req.rd_addr[IDX_W-1:0];
    assign wr_idx = req.wr_addr[IDX_W-1:0];

    // Entry valid bits: cleared at once, an invalid entry is its own root of size 1
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Single write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            parent_mem[wr_idx] <= req.wr_parent[IDX_W-1:0];
            size_mem[wr_idx]   <= req.wr_size;
        end
    end

    // Single read port, registered data
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_parent_reg <= parent_mem[rd_idx];
            rd_size_reg   <= size_mem[rd_idx];
            rd_valid_reg  <= valid_reg[rd_idx];
            rd_node_reg   <= req.rd_addr;
        end
    end

    always_comb begin
        rsp.node   = rd_node_reg;
        rsp.parent = rd_valid_reg ? VTX_W'(rd_parent_reg) : rd_node_reg;
        rsp.size   = rd_valid_reg ? rd_size_reg : SIZE_W'(1);
    end

endmodule
`default_nettype wire

// ----- hw/rtl/kuf_ctrl.sv -----
`default_nettype none
module kuf_ctrl #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input item
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_action,
    input  wire logic [kuf_pkg::VTX_W-1:0]     in_va,
    input  wire logic [kuf_pkg::VTX_W-1:0]     in_vb,
    // result item
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_accepted,
    output logic                               out_complete,
    output logic [kuf_pkg::EDGE_W-1:0]         out_edges,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [kuf_pkg::NCNT_W-1:0]    cfg_wr_data,
    // forest memory
    output kuf_pkg::kuf_mem_req_t              mem_req,
    input  wire kuf_pkg::kuf_mem_rsp_t         mem_rsp,
    output kuf_pkg::kuf_status_t               status
);
    import kuf_pkg::*;

    localparam int LIM = (MAX_NODES < VTX_LIMIT) ? MAX_NODES : VTX_LIMIT;

    kuf_state_t        state_reg, state_next;
    logic [NCNT_W-1:0] ncount_reg;
    logic [VTX_W-1:0]  vb_reg, vb_next;
    logic [VTX_W-1:0]  ra_reg, ra_next;
    logic [SIZE_W-1:0] size_a_reg, size_a_next;
    logic [VTX_W-1:0]  lo_reg, lo_next;
    logic [VTX_W-1:0]  hi_reg, hi_next;
    logic [SIZE_W-1:0] size_lo_reg, size_lo_next;
    logic [SIZE_W-1:0] sum_reg, sum_next;
    logic [EDGE_W-1:0] count_reg, count_next;
    logic              acc_reg, acc_next;

    logic              out_valid_reg;
    logic              out_acc_reg;
    logic              out_cmp_reg;
    logic [EDGE_W-1:0] out_edges_reg;

    logic [NCNT_W-1:0] n_eff;
    logic              edge_ok;
    logic              is_root;
    logic              out_free;
    logic              out_load;
    logic              complete;
    logic [SIZE_W:0]   sum_full;

    // Effective node count: node_count clamped to 2..LIM
    always_comb begin
        if (ncount_reg < NCNT_W'(2)) begin
            n_eff = NCNT_W'(2);
        end else if (ncount_reg > NCNT_W'(LIM)) begin
            n_eff = NCNT_W'(LIM);
        end else begin
            n_eff = ncount_reg;
        end
    end

    assign edge_ok  = ({1'b0, count_reg} < (n_eff - NCNT_W'(1)))
                   && ({1'b0, in_va} < n_eff) && ({1'b0, in_vb} < n_eff);
    assign is_root  = (mem_rsp.parent == mem_rsp.node);
    assign out_free = !out_valid_reg || out_ready;
    assign complete = ({1'b0, count_reg} >= (n_eff - NCNT_W'(1)));
    assign sum_full = {1'b0, size_a_reg} + {1'b0, mem_rsp.size};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_action == ACT_EDGE && edge_ok) begin
                        state_next = ST_WALK_A;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_WALK_A: begin
                if (is_root) begin
                    state_next = ST_WALK_B;
                end
            end
            ST_WALK_B: begin
                if (is_root) begin
                    state_next = (mem_rsp.node == ra_reg) ? ST_EMIT : ST_WR_LO;
                end
            end
            ST_WR_LO: state_next = ST_WR_HI;
            ST_WR_HI: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs, memory requests and datapath next values
    always_comb begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        mem_req      = '0;
        vb_next      = vb_reg;
        ra_next      = ra_reg;
        size_a_next  = size_a_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        size_lo_next = size_lo_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    vb_next  = in_vb;
                    acc_next = 1'b0;
                    if (in_action == ACT_CLEAR) begin
                        mem_req.clear = 1'b1;
                        count_next    = '0;
                    end else if (edge_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = in_va;
                    end
                end
            end
            ST_WALK_A: begin
                mem_req.rd_en = 1'b1;
                if (is_root) begin
                    ra_next         = mem_rsp.node;
                    size_a_next     = mem_rsp.size;
                    mem_req.rd_addr = vb_reg;
                end else begin
                    mem_req.rd_addr = mem_rsp.parent;
                end
            end
            ST_WALK_B: begin
                if (is_root) begin
                    // smaller set goes under the larger; a tie puts a's root under b's
                    sum_next = sum_full[SIZE_W-1:0];
                    if (size_a_reg > mem_rsp.size) begin
                        lo_next      = mem_rsp.node;
                        hi_next      = ra_reg;
                        size_lo_next = mem_rsp.size;
                    end else begin
                        lo_next      = ra_reg;
                        hi_next      = mem_rsp.node;
                        size_lo_next = size_a_reg;
                    end
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mem_rsp.parent;
                end
            end
            ST_WR_LO: begin
                mem_req.wr_en     = 1'b1;
                mem_req.wr_addr   = lo_reg;
                mem_req.wr_parent = hi_reg;
                mem_req.wr_size   = size_lo_reg;
            end
            ST_WR_HI: begin
                mem_req.wr_en     = 1'b1;
                mem_req.wr_addr   = hi_reg;
                mem_req.wr_parent = hi_reg;
                mem_req.wr_size   = sum_reg;
                count_next        = count_reg + EDGE_W'(1);
                acc_next          = 1'b1;
            end
            ST_EMIT: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ncount_reg <= NCNT_W'(VTX_LIMIT);
            count_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                ncount_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        vb_reg      <= vb_next;
        ra_reg      <= ra_next;
        size_a_reg  <= size_a_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        size_lo_reg <= size_lo_next;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
    end

    // Output register, decouples the result from the next item's work
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_acc_reg   <= acc_reg;
            out_cmp_reg   <= complete;
            out_edges_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_accepted = out_acc_reg;
    assign out_complete = out_cmp_reg;
    assign out_edges    = out_edges_reg;

    assign status.state = state_reg;
    assign status.count = count_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/kruskal_union_find.sv -----
`default_nettype none
// Kruskal spanning-tree edge selection on a disjoint-set forest with union by
// size. s_tuser[0] = 0 clears the forest (every node its own root, tree-edge
// count zero); s_tuser[0] = 1 offers the edge in s_tdata, edges presented in
// ascending cost order. Each item returns one result item. The forest sits in
// one single-port memory with registered read data, so both root walks and
// the two merge writes go through that port one access per cycle. A clear, or
// an edge rejected up front (tree complete, endpoint beyond node_count), goes
// straight to its result; any other edge first walks both endpoints to their
// roots, and a merging edge then writes the smaller root and the larger root.
// At most 5 hops per walk with 32 nodes under union by size. Entry valid bits
// reset the forest at once, so no clearing pass is needed after reset or a clear.
// The user must see that node_count is written only while idle; no check enforces it.
module kruskal_union_find #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [kuf_pkg::S_TDATA_W-1:0]   s_tdata,   // vertex_a[4:0], vertex_b[9:5]
    input  wire logic [0:0]                      s_tuser,   // action[0]
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [kuf_pkg::M_TDATA_W-1:0]        m_tdata,   // accepted[0], tree_complete[1],
                                                            // tree_edges[6:2]
    // node_count register
    input  wire logic                            cfg_wr_en,
    input  wire logic [kuf_pkg::NCNT_W-1:0]      cfg_wr_data
);
    import kuf_pkg::*;

    kuf_mem_req_t      mem_req;
    kuf_mem_rsp_t      mem_rsp;
    kuf_status_t       status;
    logic              res_accepted;
    logic              res_complete;
    logic [EDGE_W-1:0] res_edges;

    kuf_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_action    (s_tuser[0]),
        .in_va        (s_tdata[VTX_W-1:0]),
        .in_vb        (s_tdata[2*VTX_W-1:VTX_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_accepted (res_accepted),
        .out_complete (res_complete),
        .out_edges    (res_edges),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mem_req      (mem_req),
        .mem_rsp      (mem_rsp),
        .status       (status)
    );

    kuf_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rsp     (mem_rsp)
    );

    assign m_tdata = {1'b0, res_edges, res_complete, res_accepted};

    // A clear item zeroes the tree-edge count
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == ACT_CLEAR) |=> (status.count == '0))
        else $error("tree-edge count not cleared");

    // The count moves by at most one per cycle, or returns to zero
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.count == $past(status.count))
        || (status.count == $past(status.count) + EDGE_W'(1))
        || (status.count == '0))
        else $error("tree-edge count jumped");

    // An accepted edge never reports an empty tree
    a_acc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[6:2] != '0))
        else $error("accepted edge with zero tree edges");

    // Memory is never read and written in the same cycle
    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("memory port conflict");

endmodule
`default_nettype wire
